// ----- src/spike_rejecting_moving_average_core_macros.svh -----
// assertion macros for the spike rejecting moving average core
// needs clk and rst_n in the scope of the module that uses them
`ifndef SPIKE_REJECTING_MOVING_AVERAGE_CORE_MACROS_SVH
`define SPIKE_REJECTING_MOVING_AVERAGE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SRMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srma check failed");

// antecedent implies consequent in the next cycle
`define SRMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srma check failed");

`else

`define SRMA_ASSERT_NOW(label, ante, cons)
`define SRMA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/srma_pkg.sv -----
// shared types and constants for the spike rejecting moving average core
// no dependencies
package srma_pkg;

  // window and channel counts
  localparam int WINDOW   = 5;
  localparam int CHANNELS = 3;

  // field widths
  localparam int CHAN_W     = 2;
  localparam int RAW_W      = 16;
  localparam int SAMPLE_W   = 10;
  localparam int SPIKE_W    = 8;
  localparam int REJECT_W   = 3;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // raw word layout: degrees are bits 14:5, open input is bit 2
  localparam int SAMPLE_LSB = 5;
  localparam int OPEN_BIT   = 2;

  // window sum and divide by WINDOW via reciprocal multiply
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW + 1);
  localparam int RECIP_SH   = 20;
  localparam int RECIP      = ((1 << RECIP_SH) + WINDOW - 1) / WINDOW;
  localparam int RECIP_W    = $clog2(RECIP + 1);
  localparam int PROD_W     = SUM_W + RECIP_W;

  // configuration port
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam logic REG_SPIKE_LIMIT  = 1'b0;
  localparam logic REG_REJECT_LIMIT = 1'b1;
  localparam logic [SPIKE_W-1:0]  SPIKE_LIMIT_RST  = SPIKE_W'(4);
  localparam logic [REJECT_W-1:0] REJECT_LIMIT_RST = REJECT_W'(3);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] ch_row_t;

  typedef enum logic [1:0] {
    ST_PUBLISHED = 2'd0,
    ST_SPIKE     = 2'd1,
    ST_FAULT     = 2'd2,
    ST_ZERO      = 2'd3
  } status_t;

  // shift control for the window cells
  typedef struct packed {
    logic                shift;
    logic [CH_IDX_W-1:0] chan;
  } cell_ctl_t;

  // configuration register values
  typedef struct packed {
    logic [SPIKE_W-1:0]  spike_limit;
    logic [REJECT_W-1:0] reject_limit;
  } cfg_regs_t;

endpackage

// ----- src/srma_in_if.sv -----
// input item channel: channel number and raw converter word
// depends on srma_pkg
interface srma_in_if import srma_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [RAW_W-1:0]  raw_word;

  modport source (output valid, output channel, output raw_word, input ready);
  modport sink   (input valid, input channel, input raw_word, output ready);
endinterface

// ----- src/srma_out_if.sv -----
// result item channel: channel, status and window mean
// depends on srma_pkg
interface srma_out_if import srma_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   channel_out;
  logic [1:0]          status;
  logic [SAMPLE_W-1:0] temperature;

  modport source (output valid, output channel_out, output status,
                  output temperature, input ready);
  modport sink   (input valid, input channel_out, input status,
                  input temperature, output ready);
endinterface

// ----- src/srma_cell.sv -----
// one window cell: holds one window entry for every channel
// depends on srma_pkg
module srma_cell import srma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  ch_row_t   d_row,
  output ch_row_t   q_row
);

  ch_row_t q_r;
  ch_row_t q_nxt;

  // take the neighbor's entry for the selected channel
  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt[ctl.chan] = d_row[ctl.chan];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q_row = q_r;

endmodule

// ----- src/srma_cfg.sv -----
// configuration registers behind the apb-style port
// depends on srma_pkg; low address bits below the register stride are ignored
module srma_cfg import srma_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_regs_t          regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  logic      reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (reg_sel)
        REG_SPIKE_LIMIT:  regs_nxt.spike_limit  = pwdata[SPIKE_W-1:0];
        REG_REJECT_LIMIT: regs_nxt.reject_limit = pwdata[REJECT_W-1:0];
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.spike_limit  <= SPIKE_LIMIT_RST;
      regs_r.reject_limit <= REJECT_LIMIT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_SPIKE_LIMIT:  prdata = PDATA_W'(regs_r.spike_limit);
      REG_REJECT_LIMIT: prdata = PDATA_W'(regs_r.reject_limit);
      default:          prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

// ----- src/spike_rejecting_moving_average_core.sv -----
// spike rejecting moving average: the result is in the output
// register at the edge after the item is accepted
// throughput 1 item per cycle when not stalled; stored samples shift the window
// cells and the shared reject counter updates at the accept edge, so the next
// item sees the new window; reset clears the window to zero, the reject counter
// to 3 and the registers to spike limit 4, reject limit 3
`include "spike_rejecting_moving_average_core_macros.svh"

module spike_rejecting_moving_average_core import srma_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  srma_in_if.sink            in_item,
  srma_out_if.source         out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_regs_t           regs;
  cell_ctl_t           ctl;
  ch_row_t             cell_q [WINDOW];
  ch_row_t             head_row;

  logic                in_acc;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                fault;
  sample_t             sample;
  sample_t             last;
  sample_t             diff;
  logic                spike;
  logic                reject;
  logic                store;
  logic [SUM_W-1:0]    sum;
  logic [PROD_W-1:0]   prod;
  sample_t             mean;
  status_t             status;

  logic [REJECT_W-1:0] rcount_r;
  logic [REJECT_W-1:0] rcount_nxt;
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_chan_r;
  status_t             out_status_r;
  sample_t             out_temp_r;

  srma_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  // accept while the output register is empty or being drained
  assign in_item.ready = !out_valid_r || out_item.ready;
  assign in_acc        = in_item.valid && in_item.ready;

  // decode the converter word
  assign ch_ok  = (32'(in_item.channel) < CHANNELS);
  assign ch_idx = ch_ok ? in_item.channel[CH_IDX_W-1:0] : '0;
  assign fault  = !ch_ok || (in_item.raw_word == '0) || in_item.raw_word[OPEN_BIT];
  assign sample = in_item.raw_word[SAMPLE_LSB +: SAMPLE_W];

  // spike test against the newest stored entry
  assign last   = cell_q[0][ch_idx];
  assign diff   = (sample >= last) ? (sample - last) : (last - sample);
  assign spike  = diff > SAMPLE_W'(regs.spike_limit);
  assign reject = spike && (rcount_r < regs.reject_limit);
  assign store  = in_acc && !fault && !reject;

  // chain of window cells, newest entry in cell 0
  assign head_row   = {CHANNELS{sample}};
  assign ctl.shift  = store;
  assign ctl.chan   = ch_idx;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    srma_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .d_row ((k == 0) ? head_row : cell_q[(k == 0) ? 0 : k - 1]),
      .q_row (cell_q[k])
    );
  end

  // sum of the window after the new sample goes in
  always_comb begin
    sum = SUM_W'(sample);
    for (int k = 0; k < WINDOW - 1; k++) begin
      sum = sum + SUM_W'(cell_q[k][ch_idx]);
    end
  end

  // divide by the window length through a reciprocal multiply
  assign prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign mean = prod[RECIP_SH +: SAMPLE_W];

  // result status
  always_comb begin
    if (fault) begin
      status = ST_FAULT;
    end else if (reject) begin
      status = ST_SPIKE;
    end else if (mean == '0) begin
      status = ST_ZERO;
    end else begin
      status = ST_PUBLISHED;
    end
  end

  // shared reject counter
  always_comb begin
    rcount_nxt = rcount_r;
    if (in_acc && !fault && spike) begin
      rcount_nxt = reject ? (rcount_r + REJECT_W'(1)) : '0;
    end
  end

  // counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcount_r    <= REJECT_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      rcount_r <= rcount_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_chan_r   <= in_item.channel;
      out_status_r <= status;
      out_temp_r   <= (status == ST_PUBLISHED) ? mean : '0;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.channel_out = out_chan_r;
  assign out_item.status      = out_status_r;
  assign out_item.temperature = out_temp_r;

  // a bad word gives a fault result in the next cycle
  `SRMA_ASSERT_NEXT(a_fault_result, in_acc && fault, out_valid_r && (out_status_r == ST_FAULT))

  // a rejected spike bumps the shared counter by one
  `SRMA_ASSERT_NEXT(a_reject_count, in_acc && reject && !fault, rcount_r == $past(rcount_r) + 3'd1)

  // a stored sample becomes the newest entry of its channel
  `SRMA_ASSERT_NEXT(a_store_head, store, cell_q[0][$past(ch_idx)] == $past(sample))

  // only published results carry a temperature
  `SRMA_ASSERT_NOW(a_temp_zero, out_valid_r && (out_status_r != ST_PUBLISHED), out_temp_r == '0)

endmodule

// ----- test/tb_top.sv -----
// testbench for the spike rejecting moving average core: directed and random
// converter words over several limit settings, checked against a local predictor
// depends on srma_pkg, srma_in_if, srma_out_if and the core
`timescale 1ns / 1ps

module tb_top;
  import srma_pkg::*;

  localparam logic [PADDR_W-1:0] SPIKE_LIMIT_ADDR  = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] REJECT_LIMIT_ADDR = PADDR_W'(4);
  localparam int RANDOM_ITEMS = 500;
  localparam int MAX_WAIT     = 18;
  localparam int CYCLE_LIMIT  = 400000;

  // one result item as the core should produce it
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    status_t           status;
    sample_t           temperature;
  } reading_t;

  // predicts each reading from accepted items and checks the results in order
  class reading_scoreboard;
    logic [SPIKE_W-1:0]  spike_lim;
    logic [REJECT_W-1:0] reject_lim;
    logic [REJECT_W-1:0] reject_cnt;
    sample_t             window_q [CHANNELS][WINDOW];
    int                  fill_pos [CHANNELS];
    reading_t            due_readings [$];
    int                  errors;
    int                  checked;
    int                  spikes;

    function new();
      spike_lim  = SPIKE_LIMIT_RST;
      reject_lim = REJECT_LIMIT_RST;
      reject_cnt = REJECT_W'(3);
      foreach (window_q[c, k]) window_q[c][k] = '0;
      foreach (fill_pos[c]) fill_pos[c] = 0;
      errors  = 0;
      checked = 0;
      spikes  = 0;
    endfunction

    function void set_limits(logic [SPIKE_W-1:0] spike, logic [REJECT_W-1:0] reject);
      spike_lim  = spike;
      reject_lim = reject;
    endfunction

    function int pending();
      return due_readings.size();
    endfunction

    // most recent stored sample of a valid channel
    function sample_t last_degrees(logic [CHAN_W-1:0] ch);
      return (fill_pos[ch] != 0) ? window_q[ch][fill_pos[ch] - 1] : window_q[ch][0];
    endfunction

    function void predict_reading(logic [CHAN_W-1:0] ch, logic [RAW_W-1:0] word);
      reading_t r;
      sample_t  deg, last, diff;
      int       pos, sum;
      r.channel     = ch;
      r.temperature = '0;
      if (ch >= CHANNELS || word == '0 || word[OPEN_BIT]) begin
        r.status = ST_FAULT;
      end else begin
        deg  = word[SAMPLE_LSB +: SAMPLE_W];
        pos  = fill_pos[ch];
        last = last_degrees(ch);
        diff = (deg >= last) ? deg - last : last - deg;
        if (diff > spike_lim && reject_cnt < reject_lim) begin
          // spike held back, shared counter moves on
          reject_cnt = reject_cnt + 1'b1;
          r.status   = ST_SPIKE;
          spikes++;
        end else begin
          if (diff > spike_lim) reject_cnt = '0;
          if (pos >= WINDOW) pos = 0;
          window_q[ch][pos] = deg;
          fill_pos[ch]      = pos + 1;
          sum = 0;
          for (int k = 0; k < WINDOW; k++) sum += window_q[ch][k];
          if (sum / WINDOW == 0) begin
            r.status = ST_ZERO;
          end else begin
            r.status      = ST_PUBLISHED;
            r.temperature = sample_t'(sum / WINDOW);
          end
        end
      end
      due_readings.push_back(r);
    endfunction

    function void check_result(logic [CHAN_W-1:0] ch, logic [1:0] st, sample_t temp);
      reading_t want;
      checked++;
      if (due_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d with nothing outstanding: ch %0d status %0d temp %0d",
                   checked, ch, st, temp);
        return;
      end
      want = due_readings.pop_front();
      if (want.channel !== ch || want.status !== st || want.temperature !== temp) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected ch %0d status %0d temp %0d, got ch %0d status %0d temp %0d",
                   checked, want.channel, want.status, want.temperature, ch, st, temp);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int cycle_cnt;
  int items_sent;
  int settings_used;
  bit send_quiet;
  bit recv_quiet;
  reading_scoreboard readings;

  srma_in_if  in_ch ();
  srma_out_if out_ch ();

  spike_rejecting_moving_average_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  // wait length per item, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // converter word for a reading in degrees, filler bits random, open bit clear
  function automatic logic [RAW_W-1:0] pack_word(sample_t deg);
    logic [RAW_W-1:0] w;
    w = RAW_W'($urandom);
    w[SAMPLE_LSB +: SAMPLE_W] = deg;
    w[OPEN_BIT] = 1'b0;
    return w;
  endfunction

  // offer one item and wait for the core to take it
  task automatic send_item(logic [CHAN_W-1:0] ch, logic [RAW_W-1:0] word);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.channel  <= ch;
    in_ch.raw_word <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    readings.predict_reading(ch, word);
    items_sent++;
  endtask

  // register write, setup then access; the caller closes the transfer
  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic write_limits(logic [SPIKE_W-1:0] spike, logic [REJECT_W-1:0] reject);
    apb_write(SPIKE_LIMIT_ADDR, PDATA_W'(spike));
    apb_write(REJECT_LIMIT_ADDR, PDATA_W'(reject));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    readings.set_limits(spike, reject);
    settings_used++;
  endtask

  // close the input side and let every outstanding reading come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (readings.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly plausible readings near the last sample, some spikes and some noise
  task automatic make_item(output logic [CHAN_W-1:0] ch, output logic [RAW_W-1:0] word);
    int pick, last, reach, target;
    pick   = $urandom_range(0, 99);
    ch     = CHAN_W'($urandom_range(0, CHANNELS - 1));
    last   = readings.last_degrees(ch);
    reach  = readings.spike_lim;
    target = last;
    word   = '0;
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: word = '0;
        1: word = RAW_W'($urandom) | (RAW_W'(1) << OPEN_BIT);
        2: begin
          ch   = CHAN_W'(CHANNELS);
          word = pack_word(sample_t'($urandom));
        end
        default: begin
          ch   = CHAN_W'($urandom);
          word = RAW_W'($urandom);
        end
      endcase
    end else begin
      if (pick < 25) begin
        if ($urandom_range(0, 1)) target = last + reach + 1 + $urandom_range(0, 300);
        else target = last - reach - 1 - $urandom_range(0, 300);
      end else begin
        target = last + $urandom_range(0, 2 * reach) - reach;
      end
      if (target < 0) target = 0;
      if (target > 1023) target = 1023;
      word = pack_word(sample_t'(target));
    end
  endtask

  // result side: random stalls, every accepted result checked
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      readings.check_result(out_ch.channel_out, out_ch.status, out_ch.temperature);
    end
  end

  // stimulus
  initial begin
    logic [CHAN_W-1:0]   ch;
    logic [RAW_W-1:0]    word;
    logic [SPIKE_W-1:0]  spike_set [7];
    logic [REJECT_W-1:0] reject_set [7];
    int per_setting;
    readings      = new();
    items_sent    = 0;
    settings_used = 0;
    send_quiet    = 1'b0;
    recv_quiet    = 1'b0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.channel  <= '0;
    in_ch.raw_word <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed readings at the reset limits
    write_limits(SPIKE_LIMIT_RST, REJECT_LIMIT_RST);
    send_item(2'd0, 16'h0000);          // all-zero word
    send_item(2'd1, 16'h0004);          // open input only
    send_item(2'd1, 16'hFFFF);          // open input with every other bit set
    send_item(2'd3, pack_word(10'd10)); // channel out of range
    send_item(2'd0, pack_word(10'd2));  // mean still zero
    send_item(2'd0, 16'h0008);          // nonzero word reading zero degrees
    send_item(2'd0, pack_word(10'd3));
    send_item(2'd0, 16'h7FF8);          // full scale, counter at limit lets it in
    send_item(2'd1, pack_word(10'd500)); // spike held back
    send_item(2'd2, pack_word(10'd900)); // shared counter keeps climbing
    send_item(2'd1, pack_word(10'd500));
    send_item(2'd1, pack_word(10'd500)); // counter reached limit, spike taken
    send_item(2'd1, pack_word(10'd503));
    send_item(2'd1, pack_word(10'd499));
    send_item(2'd1, pack_word(10'd500));
    send_item(2'd1, pack_word(10'd502)); // ring full
    send_item(2'd1, pack_word(10'd504)); // ring wraps
    send_item(2'd2, 16'hFFFB);          // full scale with top bit set
    send_item(2'd0, pack_word(10'd1019)); // jump exactly at the limit
    send_item(2'd0, pack_word(10'd1014)); // one past the limit
    send_item(2'd2, pack_word(10'd0));
    drain();

    // random readings over limit settings including the extremes
    spike_set  = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd4, 8'd0};
    reject_set = '{3'd0, 3'd7, 3'd7, 3'd0, 3'd1, 3'd3, 3'd0};
    spike_set[6]  = SPIKE_W'($urandom_range(0, 255));
    reject_set[6] = REJECT_W'($urandom_range(0, 7));
    per_setting = RANDOM_ITEMS / 7;
    for (int s = 0; s < 7; s++) begin
      write_limits(spike_set[s], reject_set[s]);
      for (int i = 0; i < per_setting; i++) begin
        make_item(ch, word);
        send_item(ch, word);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("%0d items sent under %0d limit settings, %0d results checked",
             items_sent, settings_used, readings.checked);
    $display("%0d spikes held back, %0d failures", readings.spikes,
             readings.errors + readings.pending());
    if (readings.errors == 0 && readings.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
